@@ hw/rtl/sht_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sht_pkg: shared types and constants of the sorted hash index table
// request and response layouts, operation codes and sequencer states
// ---------------------------------------------------------------------------
package sht_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int KEY_W         = 64;
   localparam int PAYLOAD_W     = 32;
   localparam int POS_W         = 8;
   localparam int USED_W        = 9;

   // operation codes carried in the mode field
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   typedef struct packed {
      logic [1:0]           mode;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [POS_W-1:0]     position;
      logic [PAYLOAD_W-1:0] entry_data;
      logic                 table_full;
      logic [USED_W-1:0]    entries_used;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE
   } state_type;

endpackage
`default_nettype wire

@@ hw/rtl/sorted_hash_index_table.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_hash_index_table: sorted key table with binary-search lookup
// keeps up to DEPTH key/payload entries in ascending key order; inserts are
// stable (after equal keys), lookups return the first matching midpoint
//
//   channel   ports                    transfer when
//   request   start, busy, req_data    start high and busy low at a clock edge
//   response  rsp_strobe, rsp_data     rsp_strobe high, one cycle, no backpressure
//
// - clear, no-op and refused insert: response in the cycle after the transfer
// - lookup: a search state and a compare state per probe through the single
//   memory read port, plus a final search state to close an empty window;
//   response in the cycle after the last of these states
// - insert: the same search, run to an empty window, then a shift read and a
//   shift write per entry moved up, then the final write in the place state
// - busy stays high from a lookup or accepted insert transfer until its response
// - synchronous reset empties the table; no memory clearing pass is needed
//   since only entries below the entry count are ever read
// ---------------------------------------------------------------------------
module sorted_hash_index_table #(
   parameter int DEPTH = sht_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire sht_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output sht_pkg::rsp_type      rsp_data
);
   import sht_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // memory index width
   localparam int CW    = $clog2(DEPTH + 1);                // entry count width
   localparam int ENT_W = KEY_W + PAYLOAD_W;

   // entry memory: key in the upper bits, payload in the lower bits
   logic [ENT_W-1:0] mem [DEPTH];
   logic [ENT_W-1:0] rd_data_ff;

   state_type state_ff, state_in;

   logic [1:0]           op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAYLOAD_W-1:0] pay_ff, pay_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        lo_ff, lo_in;        // search window, half open
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        mid_ff, mid_in;      // probed index
   logic [CW-1:0]        ptr_ff, ptr_in;      // shift destination
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   // memory controls
   logic             mem_rd, mem_wr;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [ENT_W-1:0] wr_data;

   // shared search unit: midpoint adder and key comparator
   logic [CW:0]      mid_sum;
   logic [CW-1:0]    mid;
   logic [KEY_W-1:0] probe_key;
   logic             key_eq, key_gt;
   logic             win_open;
   logic             table_at_max;
   logic [CW-1:0]    ptr_dec;

   // insert uses floor((lo+hi)/2) over [lo,hi); lookup uses the inclusive
   // upper bound hi-1, which is safe since lo < hi whenever it is used
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff}
                    - ((op_ff == MODE_LOOKUP) ? (CW+1)'(1) : (CW+1)'(0));
   assign mid          = mid_sum[CW:1];
   assign probe_key    = rd_data_ff[ENT_W-1:PAYLOAD_W];
   assign key_eq       = (probe_key == key_ff);
   assign key_gt       = (probe_key > key_ff);
   assign win_open     = (lo_ff < hi_ff);
   assign table_at_max = (count_ff == CW'(DEPTH));
   assign ptr_dec      = ptr_ff - CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if ((req_data.mode == MODE_INSERT && !table_at_max) ||
                   req_data.mode == MODE_LOOKUP) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (win_open) begin
               state_in = ST_CMP;
            end else if (op_ff == MODE_INSERT) begin
               state_in = (count_ff > lo_ff) ? ST_SHIFT_RD : ST_PLACE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CMP: begin
            state_in = (op_ff == MODE_LOOKUP && key_eq) ? ST_IDLE : ST_SEARCH;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = (ptr_dec > lo_ff) ? ST_SHIFT_RD : ST_PLACE;
         ST_PLACE:    state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      ptr_in        = ptr_ff;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      rd_addr       = '0;
      wr_addr       = '0;
      wr_data       = {key_ff, pay_ff};
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in  = req_data.mode;
               key_in = req_data.key;
               pay_in = req_data.payload;
               lo_in  = '0;
               hi_in  = count_ff;
               case (req_data.mode)
                  MODE_INSERT: begin
                     if (table_at_max) begin
                        // full table: refuse, nothing changes
                        rsp_strobe_in     = 1'b1;
                        rsp_in.table_full = 1'b1;
                     end
                  end
                  MODE_LOOKUP: ;
                  MODE_CLEAR: begin
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: rsp_strobe_in = 1'b1;
               endcase
               rsp_in.entries_used = USED_W'(count_in);
            end
         end
         ST_SEARCH: begin
            if (win_open) begin
               mem_rd  = 1'b1;
               rd_addr = mid[AW-1:0];
               mid_in  = mid;
            end else if (op_ff == MODE_INSERT) begin
               ptr_in = count_ff;
            end else begin
               // lookup window empty: not found
               rsp_strobe_in       = 1'b1;
               rsp_in.entries_used = USED_W'(count_ff);
            end
         end
         ST_CMP: begin
            if (op_ff == MODE_LOOKUP) begin
               if (key_eq) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.found        = 1'b1;
                  rsp_in.position     = POS_W'(mid_ff);
                  rsp_in.entry_data   = rd_data_ff[PAYLOAD_W-1:0];
                  rsp_in.entries_used = USED_W'(count_ff);
               end else if (key_gt) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + CW'(1);
               end
            end else begin
               // upper bound: first stored key strictly above the new key
               if (key_gt) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + CW'(1);
               end
            end
         end
         ST_SHIFT_RD: begin
            mem_rd  = 1'b1;
            rd_addr = ptr_dec[AW-1:0];
         end
         ST_SHIFT_WR: begin
            mem_wr  = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rd_data_ff;
            ptr_in  = ptr_dec;
         end
         ST_PLACE: begin
            mem_wr              = 1'b1;
            wr_addr             = lo_ff[AW-1:0];
            wr_data             = {key_ff, pay_ff};
            count_in            = count_ff + CW'(1);
            rsp_strobe_in       = 1'b1;
            rsp_in.found        = 1'b1;
            rsp_in.position     = POS_W'(lo_ff);
            rsp_in.entries_used = USED_W'(count_in);
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      pay_ff <= pay_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // every compare follows a probe issued from the search state
   a_cmp_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> $past(state_ff) == ST_SEARCH)
      else $error("compare without probe");

   // search window stays ordered
   a_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> lo_ff <= hi_ff)
      else $error("search window inverted");

   // final write of an insert is answered on the next cycle
   a_place_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |=> rsp_strobe_ff && rsp_ff.found)
      else $error("insert without response");

   // a refused insert never reports success
   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.table_full |-> !rsp_ff.found)
      else $error("refused insert marked found");

endmodule
`default_nettype wire
